// ===== hw/rtl/morphology_3x3_filter_defines.svh =====
// Assertion macros for the morphology filter.
`ifndef MORPHOLOGY_3X3_FILTER_DEFINES_SVH
`define MORPHOLOGY_3X3_FILTER_DEFINES_SVH
`ifndef SYNTH
`define M3_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("morph3 check failed");
`define M3_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("morph3 check failed");
`else
`define M3_ASSERT(lbl, prop)
`define M3_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== hw/rtl/morph3_pkg.sv =====
package morph3_pkg;

  localparam int MAX_FIRST  = 256;
  localparam int MAX_SECOND = 256;
  localparam int DEPTH      = MAX_FIRST * MAX_SECOND;
  localparam int AW         = $clog2(DEPTH);
  localparam int FW         = $clog2(MAX_FIRST);
  localparam int SW         = $clog2(MAX_SECOND);
  localparam int NFW        = FW + 1;
  localparam int NSW        = SW + 1;

  localparam logic [7:0] PIX_MAX = 8'd255;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] MODE_BIN_ERODE  = 2'd0;
  localparam logic [1:0] MODE_BIN_DILATE = 2'd1;

  localparam logic RESP_READ = 1'b0;
  localparam logic RESP_DONE = 1'b1;

  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_HORIZ  = 3'd1;
  localparam logic [2:0] CFG_OBJ    = 3'd2;
  localparam logic [2:0] CFG_PASSES = 3'd3;
  localparam logic [2:0] CFG_SIZE_F = 3'd4;
  localparam logic [2:0] CFG_SIZE_S = 3'd5;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] pos_first;
    logic [7:0] pos_second;
    logic [7:0] pixel_in;
  } req_t;

  typedef struct packed {
    logic       resp_kind;
    logic [7:0] pixel_out;
  } resp_t;

  typedef struct packed {
    logic       clr;
    logic       acc;
    logic [1:0] mode;
    logic [7:0] obj;
  } win_ctrl_t;

  function automatic logic [AW-1:0] addr_of(logic [FW-1:0] f, logic [SW-1:0] s);
    logic [AW-1:0] base;
    base = AW'(f) * AW'(MAX_SECOND);
    return base + AW'(s);
  endfunction

endpackage

// ===== hw/rtl/morphology_3x3_filter.sv =====
// Channel  Direction  Payload  Handshake
// in       input      req_t    in_valid_i / in_ready_o
// out      output     resp_t   out_valid_o / out_ready_i
// cfg      input      9 bits   cfg_we_i, no wait
//
// A pixel write is stored on accept; a read beat passes the frame RAM read
// register and then the output register. A run walks the frame with one window
// read per cycle from the single frame read port (9 taps per window, or 3 in
// horizontal mode), then copies scratch back; a run repeats this passes_q times.
// Reset clears control and config only; both frame memories stay undefined.
// A stalled output beat blocks new requests; no request is taken during a run.
`include "morphology_3x3_filter_defines.svh"

module morphology_3x3_filter
  import morph3_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output resp_t      out_data_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [8:0] cfg_data_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_WIN  = 3'd2;
  localparam logic [2:0] S_WFIN = 3'd3;
  localparam logic [2:0] S_CP   = 3'd4;
  localparam logic [2:0] S_CPF  = 3'd5;

  // Configuration registers.
  logic [1:0] mode_q;
  logic       horiz_q;
  logic [7:0] obj_q;
  logic [7:0] passes_q;
  logic [8:0] size_f_q;
  logic [8:0] size_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BIN_ERODE;
      horiz_q  <= 1'b0;
      obj_q    <= PIX_MAX;
      passes_q <= 8'd1;
      size_f_q <= 9'd256;
      size_s_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:   mode_q   <= cfg_data_i[1:0];
        CFG_HORIZ:  horiz_q  <= cfg_data_i[0];
        CFG_OBJ:    obj_q    <= cfg_data_i[7:0];
        CFG_PASSES: passes_q <= cfg_data_i[7:0];
        CFG_SIZE_F: size_f_q <= cfg_data_i;
        CFG_SIZE_S: size_s_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturate the image extents to the storage size.
  logic [NFW-1:0] nf;
  logic [NSW-1:0] ns;
  assign nf = (32'(size_f_q) > MAX_FIRST)  ? NFW'(MAX_FIRST)  : NFW'(size_f_q);
  assign ns = (32'(size_s_q) > MAX_SECOND) ? NSW'(MAX_SECOND) : NSW'(size_s_q);

  logic [2:0]    state_q;
  logic [7:0]    pass_q;
  logic [FW-1:0] f_q;
  logic [SW-1:0] s_q;
  logic [1:0]    da_q, db_q;
  logic          vld_q;
  logic          cp_vld_q;
  logic [AW-1:0] cp_addr_q;
  logic          rd_in_q;
  logic          out_valid_q;
  resp_t         out_q;

  logic          in_acc;
  logic          req_in;
  logic [AW-1:0] req_addr;
  logic          run_empty;
  logic          last_pass;
  logic          out_set;
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign req_in     = (32'(in_data_i.pos_first) < MAX_FIRST) &&
                      (32'(in_data_i.pos_second) < MAX_SECOND);
  assign req_addr   = addr_of(FW'(in_data_i.pos_first), SW'(in_data_i.pos_second));
  assign run_empty  = (nf == '0) || (ns == '0) || (passes_q == 8'd0);
  assign last_pass  = (pass_q + 8'd1) == passes_q;

  // Raise the output beat on a read, an empty run, or the end of the last pass.
  assign out_set = (state_q == S_RD) ||
                   ((state_q == S_CPF) && last_pass) ||
                   (in_acc && (in_data_i.req_type == REQ_RUN) && run_empty);

  // Neighbor of the current pixel and whether it lies inside the image.
  logic [FW-1:0] nb_f;
  logic [SW-1:0] nb_s;
  logic          nb_ok;
  logic          f_last, s_last;
  assign f_last = (NFW'(f_q) + NFW'(1)) == nf;
  assign s_last = (NSW'(s_q) + NSW'(1)) == ns;

  always_comb begin
    case (da_q)
      2'd0:    nb_f = f_q - FW'(1);
      2'd2:    nb_f = f_q + FW'(1);
      default: nb_f = f_q;
    endcase
    case (db_q)
      2'd0:    nb_s = s_q - SW'(1);
      2'd2:    nb_s = s_q + SW'(1);
      default: nb_s = s_q;
    endcase
    nb_ok = !((da_q == 2'd0) && (f_q == '0)) && !((da_q == 2'd2) && f_last) &&
            !((db_q == 2'd0) && (s_q == '0)) && !((db_q == 2'd2) && s_last);
  end

  logic       win_last;
  logic [1:0] db_first;
  assign db_first = horiz_q ? 2'd1 : 2'd0;
  assign win_last = (da_q == 2'd2) && (horiz_q || (db_q == 2'd2));

  // Frame and scratch memory ports.
  logic          fr_we, fr_re, sc_we, sc_re;
  logic [AW-1:0] fr_waddr, fr_raddr, pix_addr;
  logic [7:0]    fr_wdata, fr_rdata, sc_rdata, win_res;
  win_ctrl_t     win_ctrl;

  assign pix_addr = addr_of(f_q, s_q);
  assign fr_we    = (in_acc && (in_data_i.req_type == REQ_WRITE) && req_in) ||
                    (((state_q == S_CP) || (state_q == S_CPF)) && cp_vld_q);
  assign fr_waddr = (state_q == S_IDLE) ? req_addr : cp_addr_q;
  assign fr_wdata = (state_q == S_IDLE) ? in_data_i.pixel_in : sc_rdata;
  assign fr_re    = (in_acc && (in_data_i.req_type == REQ_READ) && req_in) ||
                    ((state_q == S_WIN) && nb_ok);
  assign fr_raddr = (state_q == S_IDLE) ? req_addr : addr_of(nb_f, nb_s);
  assign sc_we    = (state_q == S_WFIN);
  assign sc_re    = (state_q == S_CP);

  assign win_ctrl.clr  = (state_q == S_WFIN);
  assign win_ctrl.acc  = vld_q;
  assign win_ctrl.mode = mode_q;
  assign win_ctrl.obj  = obj_q;

  morph3_ram #(.Width(8), .Depth(DEPTH)) u_frame (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .re_i    (fr_re),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  morph3_ram #(.Width(8), .Depth(DEPTH)) u_scratch (
    .clk_i   (clk_i),
    .we_i    (sc_we),
    .waddr_i (pix_addr),
    .wdata_i (win_res),
    .re_i    (sc_re),
    .raddr_i (pix_addr),
    .rdata_o (sc_rdata)
  );

  morph3_win u_win (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .pix_i  (fr_rdata),
    .res_o  (win_res)
  );

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= 8'd0;
      f_q         <= '0;
      s_q         <= '0;
      da_q        <= 2'd0;
      db_q        <= 2'd0;
      vld_q       <= 1'b0;
      cp_vld_q    <= 1'b0;
      cp_addr_q   <= '0;
      rd_in_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // hold the beat until taken, raise it when a new one is ready
      out_valid_q <= out_set || (out_valid_q && !out_ready_i);
      vld_q <= (state_q == S_WIN) && nb_ok;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (in_data_i.req_type)
              REQ_READ: begin
                rd_in_q <= req_in;
                state_q <= S_RD;
              end
              REQ_RUN: begin
                if (!run_empty) begin
                  pass_q  <= 8'd0;
                  f_q     <= '0;
                  s_q     <= '0;
                  da_q    <= 2'd0;
                  db_q    <= db_first;
                  state_q <= S_WIN;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          state_q <= S_IDLE;
        end
        S_WIN: begin
          // advance through the window, second index innermost
          if (win_last) begin
            state_q <= S_WFIN;
          end else if (horiz_q || (db_q == 2'd2)) begin
            da_q <= da_q + 2'd1;
            db_q <= db_first;
          end else begin
            db_q <= db_q + 2'd1;
          end
        end
        S_WFIN: begin
          da_q <= 2'd0;
          db_q <= db_first;
          if (s_last) begin
            s_q <= '0;
            if (f_last) begin
              f_q     <= '0;
              state_q <= S_CP;
            end else begin
              f_q     <= f_q + FW'(1);
              state_q <= S_WIN;
            end
          end else begin
            s_q     <= s_q + SW'(1);
            state_q <= S_WIN;
          end
        end
        S_CP: begin
          cp_vld_q  <= 1'b1;
          cp_addr_q <= pix_addr;
          if (s_last) begin
            s_q <= '0;
            if (f_last) begin
              f_q     <= '0;
              state_q <= S_CPF;
            end else begin
              f_q <= f_q + FW'(1);
            end
          end else begin
            s_q <= s_q + SW'(1);
          end
        end
        S_CPF: begin
          cp_vld_q <= 1'b0;
          if (last_pass) begin
            state_q <= S_IDLE;
          end else begin
            pass_q  <= pass_q + 8'd1;
            state_q <= S_WIN;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Output register: hold the beat until taken.
  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      out_q.resp_kind <= RESP_READ;
      out_q.pixel_out <= rd_in_q ? fr_rdata : 8'd0;
    end else if ((state_q == S_CPF) ||
                 (in_acc && (in_data_i.req_type == REQ_RUN))) begin
      out_q.resp_kind <= RESP_DONE;
      out_q.pixel_out <= 8'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `M3_ASSERT(a_no_beat_in_run, (state_q == S_WIN || state_q == S_WFIN || state_q == S_CP) |-> !out_valid_q)
  `M3_ASSERT(a_frame_port_excl, fr_we |-> !(fr_re && (state_q == S_WIN)))
  `M3_ASSERT(a_win_read_origin, vld_q |-> $past(state_q) == S_WIN)
  `M3_ASSERT_RST(a_reset_idle, !rst_ni |=> (state_q == S_IDLE) || rst_ni)

endmodule

// ===== hw/rtl/morph3_ram.sv =====
module morph3_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/morph3_win.sv =====
module morph3_win
  import morph3_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  win_ctrl_t  ctrl_i,
  input  logic [7:0] pix_i,
  output logic [7:0] res_o
);

  logic       all_q, all_d;
  logic       any_q, any_d;
  logic [7:0] min_q, min_d;

  // Fold the pixel that arrives this cycle into the running window state.
  always_comb begin
    all_d = all_q;
    any_d = any_q;
    min_d = min_q;
    if (ctrl_i.acc) begin
      all_d = all_q & (pix_i != 8'd0);
      any_d = any_q | (pix_i != 8'd0);
      min_d = (pix_i < min_q) ? pix_i : min_q;
    end
  end

  always_comb begin
    case (ctrl_i.mode)
      MODE_BIN_ERODE:  res_o = all_d ? ctrl_i.obj : 8'd0;
      MODE_BIN_DILATE: res_o = any_d ? ctrl_i.obj : 8'd0;
      default:         res_o = min_d;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_q <= 1'b1;
      any_q <= 1'b0;
      min_q <= PIX_MAX;
    end else if (ctrl_i.clr) begin
      all_q <= 1'b1;
      any_q <= 1'b0;
      min_q <= PIX_MAX;
    end else begin
      all_q <= all_d;
      any_q <= any_d;
      min_q <= min_d;
    end
  end

endmodule
